@@ rtl/core/fixed_point_alu_assert.svh @@
// ----------------------------------------------------------------------------
// Fixed-point ALU assertion macros
// Clocked, reset-gated property wrapper shared by the checker.
// ----------------------------------------------------------------------------
`ifndef FIXED_POINT_ALU_ASSERT_SVH
`define FIXED_POINT_ALU_ASSERT_SVH

// Check a property on every rising clock edge outside reset.
`define FPA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`endif

@@ rtl/core/fpa_pkg.sv @@
// ----------------------------------------------------------------------------
// Fixed-point ALU package
// Shared types, operation codes and saturation helpers.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int unsigned FpaFractionBits = 8;
  localparam int unsigned FpaQueueDepth   = 4;

  typedef enum logic [3:0] {
    OP_ADD    = 4'd0,
    OP_SUB    = 4'd1,
    OP_MUL    = 4'd2,
    OP_DIV    = 4'd3,
    OP_GT     = 4'd4,
    OP_LT     = 4'd5,
    OP_GE     = 4'd6,
    OP_LE     = 4'd7,
    OP_EQ     = 4'd8,
    OP_NE     = 4'd9,
    OP_MIN    = 4'd10,
    OP_MAX    = 4'd11,
    OP_INC    = 4'd12,
    OP_DEC    = 4'd13,
    OP_TO_INT = 4'd14
  } fpa_op_e;

  typedef enum logic [1:0] {
    KIND_SIMPLE,
    KIND_MUL,
    KIND_DIV
  } fpa_kind_e;

  typedef struct packed {
    logic [3:0]         operation;
    logic signed [31:0] operand_a;
    logic signed [31:0] operand_b;
  } fpa_request_t;

  typedef struct packed {
    logic signed [31:0] result_value;
    logic               compare_true;
    logic               divide_by_zero;
    logic               saturated;
  } fpa_result_t;

  typedef struct packed {
    fpa_op_e    op;
    fpa_kind_e  kind;
    logic [31:0] a;
    logic [31:0] b;
    logic        neg_a;
    logic        neg_b;
    logic [31:0] mag_a;
    logic [31:0] mag_b;
  } fpa_task_t;

  typedef struct packed {
    logic [31:0] value;
    logic        sat;
  } fpa_sat_t;

  function automatic logic [31:0] magnitude(input logic [31:0] w);
    return w[31] ? (32'd0 - w) : w;
  endfunction

  function automatic fpa_sat_t join_sat(input logic neg, input logic [63:0] mag);
    fpa_sat_t r;
    r.sat   = 1'b0;
    r.value = mag[31:0];
    if (neg) begin
      if (mag > 64'h0000_0000_8000_0000) begin
        r.sat   = 1'b1;
        r.value = 32'h8000_0000;
      end else begin
        r.value = 32'd0 - mag[31:0];
      end
    end else if (mag > 64'h0000_0000_7FFF_FFFF) begin
      r.sat   = 1'b1;
      r.value = 32'h7FFF_FFFF;
    end
    return r;
  endfunction

endpackage

@@ rtl/core/fpa_front.sv @@
// ----------------------------------------------------------------------------
// Fixed-point ALU front end
// Accepts requests, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module fpa_front import fpa_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = FpaQueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  fpa_request_t request_i,
  input  logic         pop_i,
  output logic         valid_o,
  output fpa_task_t    task_o
);

  localparam int unsigned PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  fpa_task_t             mem_q [QUEUE_DEPTH];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]       count_q, count_d;
  fpa_task_t             new_task;
  logic                  push, pop;

  always_comb begin
    new_task.op    = fpa_op_e'(request_i.operation);
    new_task.a     = request_i.operand_a;
    new_task.b     = request_i.operand_b;
    new_task.neg_a = request_i.operand_a[31];
    new_task.neg_b = request_i.operand_b[31];
    new_task.mag_a = magnitude(request_i.operand_a);
    new_task.mag_b = magnitude(request_i.operand_b);
    unique case (new_task.op)
      OP_MUL:  new_task.kind = KIND_MUL;
      OP_DIV:  new_task.kind = KIND_DIV;
      default: new_task.kind = KIND_SIMPLE;
    endcase
  end

  assign busy    = (count_q == CntW'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign task_o  = mem_q[rd_ptr_q];
  assign push    = start && !busy;
  assign pop     = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_task;
    end
  end

endmodule

@@ rtl/core/fpa_back.sv @@
// ----------------------------------------------------------------------------
// Fixed-point ALU back end
// Executes queued requests: combinational simple ops, a registered multiply and a
// bit-serial restoring divide, then drives the result strobe.
// ----------------------------------------------------------------------------
module fpa_back import fpa_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FpaFractionBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  fpa_task_t   task_i,
  output logic        pop_o,
  output logic        done_o,
  output fpa_result_t result_o
);

  localparam int unsigned NumW   = 32 + FRACTION_BITS;
  localparam int unsigned CntW   = $clog2(NumW + 1);
  localparam logic [63:0] RndAdd = (64'd1 << FRACTION_BITS) >> 1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_DIV_ROUND
  } state_e;

  state_e            state_q;
  logic [63:0]       prod_q;
  logic [NumW-1:0]   num_q, quo_q;
  logic [31:0]       rem_q, divisor_q;
  logic              neg_q;
  logic [CntW-1:0]   cnt_q;
  logic              done_q, done_d;
  fpa_result_t       result_q, result_d;

  fpa_result_t       simple_res, dz_res, mul_res, div_res;
  logic [31:0]       int_mag;
  logic [32:0]       trial, diff;
  logic              trial_ge;
  logic [63:0]       mul_mag, div_mag;
  fpa_sat_t          mul_sat, div_sat;
  logic              rnd_up;

  assign pop_o = (state_q == ST_IDLE) && valid_i;

  always_comb begin
    simple_res = '0;
    int_mag    = task_i.mag_a >> FRACTION_BITS;
    case (task_i.op)
      OP_ADD:    simple_res.result_value = task_i.a + task_i.b;
      OP_SUB:    simple_res.result_value = task_i.a - task_i.b;
      OP_GT:     simple_res.compare_true = $signed(task_i.b) < $signed(task_i.a);
      OP_LT:     simple_res.compare_true = $signed(task_i.a) < $signed(task_i.b);
      OP_GE:     simple_res.compare_true = !($signed(task_i.a) < $signed(task_i.b));
      OP_LE:     simple_res.compare_true = !($signed(task_i.b) < $signed(task_i.a));
      OP_EQ:     simple_res.compare_true = (task_i.a == task_i.b);
      OP_NE:     simple_res.compare_true = (task_i.a != task_i.b);
      OP_MIN:    simple_res.result_value =
                   ($signed(task_i.a) < $signed(task_i.b)) ? task_i.a : task_i.b;
      OP_MAX:    simple_res.result_value =
                   ($signed(task_i.b) < $signed(task_i.a)) ? task_i.a : task_i.b;
      OP_INC:    simple_res.result_value = task_i.a + 32'd1;
      OP_DEC:    simple_res.result_value = task_i.a - 32'd1;
      OP_TO_INT: simple_res.result_value = task_i.neg_a ? (32'd0 - int_mag) : int_mag;
      default:   simple_res = '0;
    endcase
  end

  always_comb begin
    trial    = {rem_q, num_q[NumW-1]};
    diff     = trial - {1'b0, divisor_q};
    trial_ge = (trial >= {1'b0, divisor_q});
    mul_mag  = (prod_q + RndAdd) >> FRACTION_BITS;
    mul_sat  = join_sat(neg_q, mul_mag);
    rnd_up   = ({rem_q, 1'b0} >= {1'b0, divisor_q});
    div_mag  = 64'(quo_q) + 64'(rnd_up);
    div_sat  = join_sat(neg_q, div_mag);

    mul_res              = '0;
    mul_res.result_value = mul_sat.value;
    mul_res.saturated    = mul_sat.sat;
    div_res              = '0;
    div_res.result_value = div_sat.value;
    div_res.saturated    = div_sat.sat;
    dz_res                = '0;
    dz_res.divide_by_zero = 1'b1;
    if (task_i.mag_a != '0) begin
      dz_res.saturated    = 1'b1;
      dz_res.result_value = task_i.neg_a ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
  end

  always_comb begin
    done_d   = 1'b0;
    result_d = result_q;
    unique case (state_q)
      ST_IDLE: begin
        if (valid_i) begin
          if (task_i.kind == KIND_DIV) begin
            if (task_i.mag_b == '0) begin
              done_d   = 1'b1;
              result_d = dz_res;
            end
          end else if (task_i.kind != KIND_MUL) begin
            done_d   = 1'b1;
            result_d = simple_res;
          end
        end
      end
      ST_MUL: begin
        done_d   = 1'b1;
        result_d = mul_res;
      end
      ST_DIV_ROUND: begin
        done_d   = 1'b1;
        result_d = div_res;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      done_q    <= 1'b0;
      result_q  <= '0;
      prod_q    <= '0;
      num_q     <= '0;
      quo_q     <= '0;
      rem_q     <= '0;
      divisor_q <= '0;
      neg_q     <= 1'b0;
      cnt_q     <= '0;
    end else begin
      done_q   <= done_d;
      result_q <= result_d;
      unique case (state_q)
        ST_IDLE: begin
          if (valid_i) begin
            neg_q <= task_i.neg_a != task_i.neg_b;
            unique case (task_i.kind)
              KIND_MUL: begin
                prod_q  <= 64'(task_i.mag_a) * 64'(task_i.mag_b);
                state_q <= ST_MUL;
              end
              KIND_DIV: begin
                if (task_i.mag_b != '0) begin
                  num_q     <= {task_i.mag_a, {FRACTION_BITS{1'b0}}};
                  quo_q     <= '0;
                  rem_q     <= '0;
                  divisor_q <= task_i.mag_b;
                  cnt_q     <= CntW'(NumW);
                  state_q   <= ST_DIV;
                end
              end
              default: ;
            endcase
          end
        end
        ST_MUL: begin
          state_q <= ST_IDLE;
        end
        ST_DIV: begin
          rem_q <= trial_ge ? diff[31:0] : trial[31:0];
          quo_q <= {quo_q[NumW-2:0], trial_ge};
          num_q <= num_q << 1;
          cnt_q <= cnt_q - CntW'(1);
          if (cnt_q == CntW'(1)) begin
            state_q <= ST_DIV_ROUND;
          end
        end
        ST_DIV_ROUND: begin
          state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

@@ rtl/core/fixed_point_alu.sv @@
// ----------------------------------------------------------------------------
// Fixed-point ALU
// Signed raw 32-bit fixed-point ALU with a request queue ahead of the
// execution unit.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy rises only when
// the request queue (QUEUE_DEPTH entries) is full. Each request gives one
// result, shown for one cycle with done_o, in request order; results cannot be
// held off. Add, subtract, compare, min/max, inc/dec and to_int are resolved
// in the idle state and sustain one request per cycle unless a multiply or
// divide holds the execution unit. Results pass the queue and result_q.
// Multiply registers the 32x32 magnitude product, then rounds and clamps it.
// Divide runs a restoring divider at one quotient bit per cycle, then rounds;
// a zero divisor is answered from the idle state without running the divider.
module fixed_point_alu import fpa_pkg::*; #(
  parameter int unsigned FRACTION_BITS = FpaFractionBits,
  parameter int unsigned QUEUE_DEPTH   = FpaQueueDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         start,
  output logic         busy,
  input  fpa_request_t request_i,
  output logic         done_o,
  output fpa_result_t  result_o
);

  logic      task_valid, task_pop;
  fpa_task_t task_head;

  fpa_front #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .request_i(request_i),
    .pop_i    (task_pop),
    .valid_o  (task_valid),
    .task_o   (task_head)
  );

  fpa_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (task_valid),
    .task_i  (task_head),
    .pop_o   (task_pop),
    .done_o  (done_o),
    .result_o(result_o)
  );

endmodule

@@ rtl/core/fpa_checker.sv @@
// ----------------------------------------------------------------------------
// Fixed-point ALU port checker
// Consistency checks on result flags and on idle after reset, bound to the top level.
// ----------------------------------------------------------------------------
`include "fixed_point_alu_assert.svh"

module fpa_checker import fpa_pkg::*; (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         busy,
  input logic         done_o,
  input fpa_result_t  result_o
);

  logic cmp_hit, cmp_clean, dz_sat_hit, dz_zero_hit, at_limit;

  assign cmp_hit     = done_o && result_o.compare_true;
  assign cmp_clean   = (result_o.result_value == 32'd0) && !result_o.saturated
                       && !result_o.divide_by_zero;
  assign dz_sat_hit  = done_o && result_o.divide_by_zero && result_o.saturated;
  assign dz_zero_hit = done_o && result_o.divide_by_zero && !result_o.saturated;
  assign at_limit    = (result_o.result_value == 32'h7FFF_FFFF)
                       || (result_o.result_value == 32'h8000_0000);

  `FPA_ASSERT(a_cmp_clean, cmp_hit |-> cmp_clean, "comparison result carries value or flags")
  `FPA_ASSERT(a_dz_sat_limit, dz_sat_hit |-> at_limit, "zero divisor clamp not at a limit")
  `FPA_ASSERT(a_dz_zero, dz_zero_hit |-> result_o.result_value == 32'd0, "zero over zero not zero")
  `FPA_ASSERT(a_idle_after_reset, $rose(rst_ni) |-> !done_o && !busy, "not idle after reset")

endmodule

bind fixed_point_alu fpa_checker u_fpa_checker (.*);
